[sv/fds_pkg.sv]
// Fall detection sequencer package: event, phase, command and display codes,
// configuration register map and the control state record.
// No dependencies.
package fds_pkg;

    // Event kinds carried in the mode field of an input word
    typedef enum logic [2:0] {
        MODE_SEC_TICK   = 3'd0,
        MODE_BLINK_TICK = 3'd1,
        MODE_POWER_BTN  = 3'd2,
        MODE_RESET_BTN  = 3'd3,
        MODE_SENSOR     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_ARMED     = 2'd0,
        PH_FREE_FALL = 2'd1,
        PH_IMPACT    = 2'd2,
        PH_FALLEN    = 2'd3
    } phase_t;

    // Sensor reconfiguration commands
    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_ARM_FF    = 2'd1,
        CMD_MOTION    = 2'd2,
        CMD_FREE_FALL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DISP_BLANK = 2'd0,
        DISP_ZERO  = 2'd1,
        DISP_ONE   = 2'd2
    } display_t;

    // APB register map (word index = paddr[4:2])
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_TILT    = 3'd1;
    localparam logic [2:0] REG_REF_X   = 3'd2;
    localparam logic [2:0] REG_REF_Y   = 3'd3;
    localparam logic [2:0] REG_REF_Z   = 3'd4;

    localparam logic        [15:0] TIMEOUT_RST = 16'd5;
    localparam logic        [7:0]  TILT_RST    = 8'd5;
    localparam logic signed [7:0]  REF_X_RST   = 8'sd0;
    localparam logic signed [7:0]  REF_Y_RST   = -8'sd16;
    localparam logic signed [7:0]  REF_Z_RST   = 8'sd0;

    typedef struct packed {
        logic        [15:0] timeout_ticks;
        logic        [7:0]  tilt_threshold;
        logic signed [7:0]  ref_x;
        logic signed [7:0]  ref_y;
        logic signed [7:0]  ref_z;
    } cfg_t;

    // Control state kept between events; also forms most of a result word
    typedef struct packed {
        phase_t   phase;
        logic     active;
        logic     red;
        logic     green;
        display_t display;
    } ctrl_state_t;

endpackage

[sv/fds_ifs.sv]
// Fall detection sequencer channel interfaces: event input and result output.
// Plain valid/ready handshake; a word moves when valid and ready are both high.
// No dependencies.
interface fds_evt_if;
    logic              valid;
    logic              ready;
    logic        [2:0] mode;
    logic signed [7:0] accel_x;
    logic signed [7:0] accel_y;
    logic signed [7:0] accel_z;

    modport source (output valid, mode, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, mode, accel_x, accel_y, accel_z, output ready);
endinterface

interface fds_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] sensor_command;
    logic [1:0] phase;
    logic       is_active;
    logic       red_light;
    logic       green_light;
    logic [1:0] display_code;

    modport source (output valid, sensor_command, phase, is_active, red_light,
                    green_light, display_code, input ready);
    modport sink   (input valid, sensor_command, phase, is_active, red_light,
                    green_light, display_code, output ready);
endinterface

[sv/fds_cfg_regs.sv]
// Fall detection sequencer configuration registers behind an APB-style port.
// Depends on fds_pkg.
module fds_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fds_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fds_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fds_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output fds_pkg::cfg_t                       cfg
);

    fds_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks  <= fds_pkg::TIMEOUT_RST;
            cfg_reg.tilt_threshold <= fds_pkg::TILT_RST;
            cfg_reg.ref_x          <= fds_pkg::REF_X_RST;
            cfg_reg.ref_y          <= fds_pkg::REF_Y_RST;
            cfg_reg.ref_z          <= fds_pkg::REF_Z_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                fds_pkg::REG_TIMEOUT: cfg_reg.timeout_ticks  <= pwdata[15:0];
                fds_pkg::REG_TILT:    cfg_reg.tilt_threshold <= pwdata[7:0];
                fds_pkg::REG_REF_X:   cfg_reg.ref_x          <= pwdata[7:0];
                fds_pkg::REG_REF_Y:   cfg_reg.ref_y          <= pwdata[7:0];
                fds_pkg::REG_REF_Z:   cfg_reg.ref_z          <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Signed references read back sign-extended
    always_comb
    begin
        case (reg_idx)
            fds_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_reg.timeout_ticks};
            fds_pkg::REG_TILT:    prdata = {24'd0, cfg_reg.tilt_threshold};
            fds_pkg::REG_REF_X:   prdata = {{24{cfg_reg.ref_x[7]}}, cfg_reg.ref_x};
            fds_pkg::REG_REF_Y:   prdata = {{24{cfg_reg.ref_y[7]}}, cfg_reg.ref_y};
            fds_pkg::REG_REF_Z:   prdata = {{24{cfg_reg.ref_z[7]}}, cfg_reg.ref_z};
            default:              prdata = '0;
        endcase
    end

endmodule

[sv/fds_step.sv]
// Fall detection sequencer event step: next control state, tick counters and
// sensor command for one event. Purely combinational.
// Depends on fds_pkg.
module fds_step #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  fds_pkg::ctrl_state_t    state_cur,
    input  logic [TICK_WIDTH-1:0]   tick_cur,
    input  logic [TICK_WIDTH-1:0]   last_cur,
    input  fds_pkg::cfg_t           cfg,
    input  logic [2:0]              mode,
    input  logic signed [7:0]       accel_x,
    input  logic signed [7:0]       accel_y,
    input  logic signed [7:0]       accel_z,
    output fds_pkg::ctrl_state_t    state_nxt,
    output logic [TICK_WIDTH-1:0]   tick_nxt,
    output logic [TICK_WIDTH-1:0]   last_nxt,
    output fds_pkg::cmd_t           cmd
);

    localparam int unsigned CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    function automatic logic [8:0] abs_diff(logic signed [7:0] a, logic signed [7:0] b);
        logic [8:0] d;
        d = {a[7], a} - {b[7], b};
        return d[8] ? (~d + 9'd1) : d;
    endfunction

    fds_pkg::phase_t       event_phase;
    fds_pkg::cmd_t         event_cmd;
    logic                  fell;
    logic                  timed_out;
    logic [TICK_WIDTH-1:0] elapsed;
    logic [8:0]            thr;

    assign thr  = {1'b0, cfg.tilt_threshold};
    assign fell = (abs_diff(accel_y, cfg.ref_y) >= thr) &&
                  ((abs_diff(accel_x, cfg.ref_x) >= thr) ||
                   (abs_diff(accel_z, cfg.ref_z) >= thr));

    // Phase as moved by the event itself, plus tick bookkeeping
    always_comb
    begin
        event_phase = state_cur.phase;
        tick_nxt    = tick_cur;
        last_nxt    = last_cur;
        case (mode)
            fds_pkg::MODE_SEC_TICK:
                tick_nxt = tick_cur + TICK_WIDTH'(1);
            fds_pkg::MODE_POWER_BTN:
                if (!state_cur.active)
                    event_phase = fds_pkg::PH_ARMED;
            fds_pkg::MODE_RESET_BTN:
                if (state_cur.active)
                    event_phase = fds_pkg::PH_ARMED;
            fds_pkg::MODE_SENSOR:
                if (state_cur.active)
                begin
                    last_nxt = tick_cur;
                    unique case (state_cur.phase)
                        fds_pkg::PH_ARMED:     event_phase = fds_pkg::PH_FREE_FALL;
                        fds_pkg::PH_FREE_FALL: event_phase = fds_pkg::PH_IMPACT;
                        fds_pkg::PH_IMPACT:    event_phase = fell ? fds_pkg::PH_FALLEN
                                                                  : fds_pkg::PH_ARMED;
                        fds_pkg::PH_FALLEN:    event_phase = fds_pkg::PH_FALLEN;
                    endcase
                end
            default: ;
        endcase
    end

    // Timeout: drop back to armed once the wait since the last sensor word runs out
    assign elapsed = tick_nxt - last_nxt;

    always_comb
    begin
        timed_out = 1'b0;
        if (event_phase == fds_pkg::PH_FREE_FALL || event_phase == fds_pkg::PH_IMPACT)
            timed_out = CMP_W'(elapsed) >= CMP_W'(cfg.timeout_ticks);
    end

    // Phase, command, LEDs, display and active flag
    always_comb
    begin
        event_cmd         = fds_pkg::CMD_NONE;
        state_nxt.phase   = timed_out ? fds_pkg::PH_ARMED : event_phase;
        state_nxt.active  = state_cur.active;
        state_nxt.red     = state_cur.red;
        state_nxt.green   = state_cur.green;
        state_nxt.display = state_cur.display;
        case (mode)
            fds_pkg::MODE_SEC_TICK:
                if (state_cur.active)
                    state_nxt.green = !state_cur.green;
            fds_pkg::MODE_BLINK_TICK:
                if (state_cur.active && state_cur.phase == fds_pkg::PH_FALLEN)
                    state_nxt.red = !state_cur.red;
            fds_pkg::MODE_POWER_BTN:
                if (!state_cur.active)
                begin
                    state_nxt.active  = 1'b1;
                    event_cmd         = fds_pkg::CMD_ARM_FF;
                    state_nxt.green   = 1'b1;
                    state_nxt.display = fds_pkg::DISP_ZERO;
                end
                else
                begin
                    state_nxt.active  = 1'b0;
                    state_nxt.display = fds_pkg::DISP_BLANK;
                    state_nxt.red     = 1'b0;
                    state_nxt.green   = 1'b0;
                end
            fds_pkg::MODE_RESET_BTN:
                if (state_cur.active)
                begin
                    event_cmd         = fds_pkg::CMD_ARM_FF;
                    state_nxt.display = fds_pkg::DISP_ZERO;
                    state_nxt.red     = 1'b0;
                end
            fds_pkg::MODE_SENSOR:
                if (state_cur.active)
                begin
                    unique case (state_cur.phase)
                        fds_pkg::PH_ARMED:     event_cmd = fds_pkg::CMD_MOTION;
                        fds_pkg::PH_FREE_FALL: event_cmd = fds_pkg::CMD_FREE_FALL;
                        fds_pkg::PH_IMPACT:
                            if (fell)
                            begin
                                state_nxt.red     = 1'b1;
                                state_nxt.display = fds_pkg::DISP_ONE;
                            end
                            else
                                event_cmd = fds_pkg::CMD_ARM_FF;
                        fds_pkg::PH_FALLEN:    event_cmd = fds_pkg::CMD_NONE;
                    endcase
                end
            default: ;
        endcase
        cmd = timed_out ? fds_pkg::CMD_ARM_FF : event_cmd;
    end

endmodule

[sv/fall_detect_sequencer.sv]
// Fall detection sequencer top level: event input register, step logic,
// control state and result register. Depends on fds_pkg, fds_ifs, fds_cfg_regs, fds_step.
// A word accepted into the input register is stepped into the control state and result
// register once the result register is free or being emptied. Throughput: one event word
// per cycle unless results stall; the step logic closes its state loop combinationally.
// Reset: rst_n is asynchronous, active low; clears phase, flags, LEDs, display,
// tick counters and both pipeline valids, and loads the register defaults.
module fall_detect_sequencer #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    fds_evt_if.sink                          evt,
    fds_res_if.source                        res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fds_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fds_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    fds_pkg::cfg_t cfg;

    // Input stage: one event word waiting for the step logic
    logic              in_valid_reg;
    logic              in_valid_next;
    logic        [2:0] in_mode_reg;
    logic signed [7:0] in_x_reg;
    logic signed [7:0] in_y_reg;
    logic signed [7:0] in_z_reg;

    // Control state; it also supplies the result fields other than the command
    fds_pkg::ctrl_state_t  ctrl_reg;
    fds_pkg::ctrl_state_t  ctrl_next;
    logic [TICK_WIDTH-1:0] tick_reg;
    logic [TICK_WIDTH-1:0] tick_next;
    logic [TICK_WIDTH-1:0] last_tick_reg;
    logic [TICK_WIDTH-1:0] last_tick_next;

    // Result stage
    logic          out_valid_reg;
    logic          out_valid_next;
    fds_pkg::cmd_t cmd_reg;
    fds_pkg::cmd_t cmd_next;

    logic take_in;   // event word enters the input stage
    logic advance;   // result register free or being emptied this cycle
    logic fire;      // step the waiting word and commit its state

    fds_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fds_step #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_step (
        .state_cur (ctrl_reg),
        .tick_cur  (tick_reg),
        .last_cur  (last_tick_reg),
        .cfg       (cfg),
        .mode      (in_mode_reg),
        .accel_x   (in_x_reg),
        .accel_y   (in_y_reg),
        .accel_z   (in_z_reg),
        .state_nxt (ctrl_next),
        .tick_nxt  (tick_next),
        .last_nxt  (last_tick_next),
        .cmd       (cmd_next)
    );

    // Handshake: the input stage refills in the same cycle it drains, so a
    // stalled result only blocks new words once the input stage is also full.
    assign advance   = !out_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign evt.ready = !in_valid_reg || advance;
    assign take_in   = evt.valid && evt.ready;

    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = fire || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the event word; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_mode_reg <= evt.mode;
            in_x_reg    <= evt.accel_x;
            in_y_reg    <= evt.accel_y;
            in_z_reg    <= evt.accel_z;
        end
    end

    // Commit state and command together, so the result register and the
    // control state always describe the same event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase   <= fds_pkg::PH_ARMED;
            ctrl_reg.active  <= 1'b0;
            ctrl_reg.red     <= 1'b0;
            ctrl_reg.green   <= 1'b0;
            ctrl_reg.display <= fds_pkg::DISP_BLANK;
            tick_reg         <= '0;
            last_tick_reg    <= '0;
        end
        else if (fire)
        begin
            ctrl_reg      <= ctrl_next;
            tick_reg      <= tick_next;
            last_tick_reg <= last_tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            cmd_reg <= cmd_next;
    end

    // Result word: command from the result register, the rest from state
    assign res.valid          = out_valid_reg;
    assign res.sensor_command = cmd_reg;
    assign res.phase          = ctrl_reg.phase;
    assign res.is_active      = ctrl_reg.active;
    assign res.red_light      = ctrl_reg.red;
    assign res.green_light    = ctrl_reg.green;
    assign res.display_code   = ctrl_reg.display;

    // A result only appears after a waiting word was stepped
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a waiting event word");

    // A stalled result freezes the state it reports
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> ($stable(ctrl_reg) && $stable(tick_reg)))
        else $error("state moved while result was stalled");

    // Alarm LED only lit while active and fallen
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.red |-> (ctrl_reg.active && ctrl_reg.phase == fds_pkg::PH_FALLEN))
        else $error("alarm LED lit outside fallen phase");

    // Standby keeps display blank and activity LED off
    assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_reg.active |-> (ctrl_reg.display == fds_pkg::DISP_BLANK && !ctrl_reg.green))
        else $error("display or activity LED on in standby");

endmodule

[bench/fall_detect_sequencer_tb.sv]
// Self-checking testbench for fall_detect_sequencer: event words in, one result word out.
// Depends on fds_pkg, fds_ifs and the RTL; drives events and APB writes, checks every result.
`timescale 1ns / 1ps

module fall_detect_sequencer_tb;

    localparam int unsigned TICK_W         = 16;
    localparam int          WATCHDOG_LIMIT = 200;
    localparam int          WORDS_PER_PASS = 70;
    localparam int          PASS_COUNT     = 6;
    localparam int          PRINT_CAP      = 50;

    // Event codes the block does not define; they only reach the timeout check
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [2:0]        mode;
        logic signed [7:0] ax;
        logic signed [7:0] ay;
        logic signed [7:0] az;
    } event_word_t;

    typedef struct {
        fds_pkg::cmd_t     cmd;
        fds_pkg::phase_t   phase;
        logic              active;
        logic              red;
        logic              green;
        fds_pkg::display_t disp;
    } outcome_t;

    logic clk;
    logic rst_n;

    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [fds_pkg::APB_ADDR_W-1:0]   paddr;
    logic [fds_pkg::APB_DATA_W-1:0]   pwdata;
    logic [fds_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    fds_evt_if evt_ch ();
    fds_res_if res_ch ();

    fall_detect_sequencer #(
        .TICK_WIDTH (TICK_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Detector mirror: configuration and control state as the block keeps them
    // ------------------------------------------------------------------
    logic [15:0]       cfg_timeout;
    logic [7:0]        cfg_tilt;
    logic signed [7:0] cfg_ref_x;
    logic signed [7:0] cfg_ref_y;
    logic signed [7:0] cfg_ref_z;

    fds_pkg::phase_t   phase_now;
    logic              active_now;
    logic [TICK_W-1:0] tick_now;
    logic [TICK_W-1:0] last_sensor_tick;
    logic              red_now;
    logic              green_now;
    fds_pkg::display_t disp_now;

    event_word_t event_backlog[$];       // words waiting for the driver
    outcome_t    predicted_outcomes[$];  // results owed by the block, oldest first

    // Generator-side view of the block: only the power button moves the
    // active flag, so the generator can follow it without the mirror.
    logic        gen_active;
    int          live_words;

    int send_gap;
    int sink_gap;
    int gap_odds;
    int stall_odds;
    int quiet_cycles;

    int words_accepted;
    int results_checked;
    int reg_writes;
    int mismatch_count;

    // ------------------------------------------------------------------
    // Clock, detector mirror update and mismatch report
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int axis_gap(input logic signed [7:0] a, input logic signed [7:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    // Work out the result of one accepted event word and queue it
    function automatic void advance_detector(input logic [2:0] mode,
                                             input logic signed [7:0] ax,
                                             input logic signed [7:0] ay,
                                             input logic signed [7:0] az);
        fds_pkg::cmd_t     cmd;
        logic              fell;
        logic [TICK_W-1:0] elapsed;
        outcome_t          o;
        cmd = fds_pkg::CMD_NONE;
        case (mode)
            fds_pkg::MODE_SEC_TICK:
            begin
                tick_now = tick_now + TICK_W'(1);
                if (active_now)
                    green_now = ~green_now;
            end
            fds_pkg::MODE_BLINK_TICK:
            begin
                if (active_now && phase_now == fds_pkg::PH_FALLEN)
                    red_now = ~red_now;
            end
            fds_pkg::MODE_POWER_BTN:
            begin
                active_now = ~active_now;
                if (active_now)
                begin
                    cmd       = fds_pkg::CMD_ARM_FF;
                    phase_now = fds_pkg::PH_ARMED;
                    green_now = 1'b1;
                    disp_now  = fds_pkg::DISP_ZERO;
                end
                else
                begin
                    // standby keeps the phase but darkens everything
                    disp_now  = fds_pkg::DISP_BLANK;
                    red_now   = 1'b0;
                    green_now = 1'b0;
                end
            end
            fds_pkg::MODE_RESET_BTN:
            begin
                if (active_now)
                begin
                    cmd       = fds_pkg::CMD_ARM_FF;
                    phase_now = fds_pkg::PH_ARMED;
                    disp_now  = fds_pkg::DISP_ZERO;
                    red_now   = 1'b0;
                end
            end
            fds_pkg::MODE_SENSOR:
            begin
                if (active_now)
                begin
                    last_sensor_tick = tick_now;
                    case (phase_now)
                        fds_pkg::PH_ARMED:
                        begin
                            phase_now = fds_pkg::PH_FREE_FALL;
                            cmd       = fds_pkg::CMD_MOTION;
                        end
                        fds_pkg::PH_FREE_FALL:
                        begin
                            phase_now = fds_pkg::PH_IMPACT;
                            cmd       = fds_pkg::CMD_FREE_FALL;
                        end
                        fds_pkg::PH_IMPACT:
                        begin
                            // fallen: Y tilted plus either X or Z tilted
                            fell = axis_gap(ay, cfg_ref_y) >= int'(cfg_tilt) &&
                                   (axis_gap(ax, cfg_ref_x) >= int'(cfg_tilt) ||
                                    axis_gap(az, cfg_ref_z) >= int'(cfg_tilt));
                            if (fell)
                            begin
                                red_now   = 1'b1;
                                disp_now  = fds_pkg::DISP_ONE;
                                phase_now = fds_pkg::PH_FALLEN;
                            end
                            else
                            begin
                                cmd       = fds_pkg::CMD_ARM_FF;
                                phase_now = fds_pkg::PH_ARMED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        // Timeout runs after every event and overrides the event's own command;
        // the tick difference wraps with the counter width.
        if (phase_now == fds_pkg::PH_FREE_FALL || phase_now == fds_pkg::PH_IMPACT)
        begin
            elapsed = tick_now - last_sensor_tick;
            if (elapsed >= cfg_timeout)
            begin
                cmd       = fds_pkg::CMD_ARM_FF;
                phase_now = fds_pkg::PH_ARMED;
            end
        end

        o.cmd    = cmd;
        o.phase  = phase_now;
        o.active = active_now;
        o.red    = red_now;
        o.green  = green_now;
        o.disp   = disp_now;
        predicted_outcomes.push_back(o);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, results_checked, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic logic signed [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Pick an axis value right at, just inside or anywhere around the tilt
    // boundary of one reference, clamped to the 8-bit range
    function automatic logic signed [7:0] near_ref(input logic signed [7:0] base,
                                                   input logic [7:0] thr);
        int v;
        case ($urandom_range(0, 4))
            0:       v = int'(base) + int'(thr);
            1:       v = int'(base) - int'(thr);
            2:       v = int'(base) + int'(thr) - 1;
            3:       v = int'(base) - int'(thr) + 1;
            default: v = int'($urandom_range(0, 255)) - 128;
        endcase
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return 8'(v);
    endfunction

    task automatic queue_word(input logic [2:0] mode, input logic signed [7:0] ax,
                              input logic signed [7:0] ay, input logic signed [7:0] az);
        event_word_t w;
        w.mode = mode;
        w.ax   = ax;
        w.ay   = ay;
        w.az   = az;
        event_backlog.push_back(w);
        if (mode == fds_pkg::MODE_POWER_BTN)
            gen_active = ~gen_active;
        // standby events and spare codes only idle the block; don't count them
        if (mode <= fds_pkg::MODE_SENSOR &&
            (gen_active || mode == fds_pkg::MODE_POWER_BTN ||
             mode == fds_pkg::MODE_SEC_TICK))
            live_words++;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_word(fds_pkg::MODE_SEC_TICK, rnd8(), rnd8(), rnd8());
    endtask

    // One detection attempt: arm, free fall, impact with a tilt near the
    // boundary, then some blinking; a share of noise and broken attempts.
    task automatic queue_episode();
        int span;
        span = (cfg_timeout > 16'd6) ? 6 : int'(cfg_timeout);
        if (!gen_active || $urandom_range(0, 39) == 0)
            queue_word(fds_pkg::MODE_POWER_BTN, rnd8(), rnd8(), rnd8());
        if ($urandom_range(0, 99) < 15)
        begin
            queue_word(3'($urandom_range(0, MODE_UNUSED_LAST)), rnd8(), rnd8(), rnd8());
            return;
        end
        if ($urandom_range(0, 3) != 0)
            queue_word(fds_pkg::MODE_RESET_BTN, rnd8(), rnd8(), rnd8());
        queue_word(fds_pkg::MODE_SENSOR, rnd8(), rnd8(), rnd8());
        queue_ticks($urandom_range(0, span + 1));
        queue_word(fds_pkg::MODE_SENSOR, rnd8(), rnd8(), rnd8());
        queue_ticks($urandom_range(0, span + 1));
        queue_word(fds_pkg::MODE_SENSOR, near_ref(cfg_ref_x, cfg_tilt),
                   near_ref(cfg_ref_y, cfg_tilt), near_ref(cfg_ref_z, cfg_tilt));
        repeat ($urandom_range(0, 3))
            queue_word(fds_pkg::MODE_BLINK_TICK, rnd8(), rnd8(), rnd8());
        if ($urandom_range(0, 2) == 0)
            queue_word(fds_pkg::MODE_SENSOR, rnd8(), rnd8(), rnd8());
    endtask

    task automatic queue_directed();
        // standby ignores sensor, reset and blink; the tick still counts
        queue_word(fds_pkg::MODE_SENSOR, 8'sd127, -8'sd128, 8'sd0);
        queue_word(fds_pkg::MODE_RESET_BTN, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_BLINK_TICK, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_SEC_TICK, -8'sd1, -8'sd1, -8'sd1);
        queue_word(fds_pkg::MODE_POWER_BTN, 8'sd0, 8'sd0, 8'sd0);
        // full path to fallen with extreme samples, then blink the alarm
        queue_word(fds_pkg::MODE_SENSOR, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_SENSOR, -8'sd1, -8'sd1, -8'sd1);
        queue_word(fds_pkg::MODE_SENSOR, 8'sd127, 8'sd127, -8'sd128);
        queue_word(fds_pkg::MODE_BLINK_TICK, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_BLINK_TICK, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_SENSOR, -8'sd128, -8'sd128, -8'sd128);
        queue_word(fds_pkg::MODE_RESET_BTN, 8'sd0, 8'sd0, 8'sd0);
        // impact while upright: back to armed
        queue_word(fds_pkg::MODE_SENSOR, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_SENSOR, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_SENSOR, -8'sd128, -8'sd16, -8'sd128);
        // free fall left alone until the timeout fires on the fifth tick
        queue_word(fds_pkg::MODE_SENSOR, 8'sd0, 8'sd0, 8'sd0);
        queue_ticks(5);
        queue_word(MODE_UNUSED_FIRST, 8'sd127, 8'sd127, 8'sd127);
        queue_word(MODE_UNUSED_LAST, -8'sd128, -8'sd128, -8'sd128);
        queue_word(fds_pkg::MODE_POWER_BTN, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_POWER_BTN, 8'sd0, 8'sd0, 8'sd0);
        // tilt exactly at the threshold on Y and X counts as a fall
        queue_word(fds_pkg::MODE_SENSOR, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_SENSOR, 8'sd0, 8'sd0, 8'sd0);
        queue_word(fds_pkg::MODE_SENSOR, 8'sd5, -8'sd11, 8'sd0);
    endtask

    // ------------------------------------------------------------------
    // APB writes; the mirror takes the new value once the access completes
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx,
                             input logic [fds_pkg::APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fds_pkg::REG_TIMEOUT: cfg_timeout = value[15:0];
            fds_pkg::REG_TILT:    cfg_tilt    = value[7:0];
            fds_pkg::REG_REF_X:   cfg_ref_x   = value[7:0];
            fds_pkg::REG_REF_Y:   cfg_ref_y   = value[7:0];
            fds_pkg::REG_REF_Z:   cfg_ref_z   = value[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Upper bits of each write are junk; the block must ignore them
    task automatic program_detector(input logic [15:0] timeout, input logic [7:0] tilt,
                                    input logic signed [7:0] rx, input logic signed [7:0] ry,
                                    input logic signed [7:0] rz);
        write_reg(fds_pkg::REG_TIMEOUT, {16'($urandom), timeout});
        write_reg(fds_pkg::REG_TILT,    {24'($urandom), tilt});
        write_reg(fds_pkg::REG_REF_X,   {24'($urandom), rx});
        write_reg(fds_pkg::REG_REF_Y,   {24'($urandom), ry});
        write_reg(fds_pkg::REG_REF_Z,   {24'($urandom), rz});
    endtask

    // Hold until every queued word is taken and every result is back
    task automatic wait_drained();
        do @(posedge clk);
        while (event_backlog.size() != 0 || evt_ch.valid || predicted_outcomes.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Event driver: one word on the bus at a time, held until ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : feed_events
        event_word_t w;
        if (!rst_n)
            evt_ch.valid <= 1'b0;
        else
        begin
            if (evt_ch.valid && evt_ch.ready)
            begin
                advance_detector(evt_ch.mode, evt_ch.accel_x, evt_ch.accel_y, evt_ch.accel_z);
                words_accepted++;
            end
            // advance only when the bus is free or its word just moved
            if (!evt_ch.valid || evt_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    evt_ch.valid <= 1'b0;
                end
                else if (event_backlog.size() > 0)
                begin
                    w = event_backlog.pop_front();
                    evt_ch.mode    <= w.mode;
                    evt_ch.accel_x <= w.ax;
                    evt_ch.accel_y <= w.ay;
                    evt_ch.accel_z <= w.az;
                    evt_ch.valid   <= 1'b1;
                    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                        send_gap = $urandom_range(1, 3);
                end
                else
                    evt_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_checked++;
                if (predicted_outcomes.size() == 0)
                    report_mismatch("result with nothing owed, command",
                                    int'(res_ch.sensor_command), -1);
                else
                begin
                    want = predicted_outcomes.pop_front();
                    if (res_ch.sensor_command !== want.cmd)
                        report_mismatch("sensor_command", int'(res_ch.sensor_command),
                                        int'(want.cmd));
                    if (res_ch.phase !== want.phase)
                        report_mismatch("phase", int'(res_ch.phase), int'(want.phase));
                    if (res_ch.is_active !== want.active)
                        report_mismatch("is_active", int'(res_ch.is_active),
                                        int'(want.active));
                    if (res_ch.red_light !== want.red)
                        report_mismatch("red_light", int'(res_ch.red_light), int'(want.red));
                    if (res_ch.green_light !== want.green)
                        report_mismatch("green_light", int'(res_ch.green_light),
                                        int'(want.green));
                    if (res_ch.display_code !== want.disp)
                        report_mismatch("display_code", int'(res_ch.display_code),
                                        int'(want.disp));
                end
            end
            // back-pressure in short bursts
            if (sink_gap > 0)
            begin
                sink_gap--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                    sink_gap = $urandom_range(1, 3);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any word moving means the block is stuck
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles, %0d results still owed",
                         quiet_cycles, predicted_outcomes.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: directed opening, then six settings of random episodes
    // ------------------------------------------------------------------
    initial
    begin
        int target;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        evt_ch.valid   = 1'b0;
        evt_ch.mode    = fds_pkg::MODE_SEC_TICK;
        evt_ch.accel_x = '0;
        evt_ch.accel_y = '0;
        evt_ch.accel_z = '0;
        res_ch.ready   = 1'b0;

        cfg_timeout      = fds_pkg::TIMEOUT_RST;
        cfg_tilt         = fds_pkg::TILT_RST;
        cfg_ref_x        = fds_pkg::REF_X_RST;
        cfg_ref_y        = fds_pkg::REF_Y_RST;
        cfg_ref_z        = fds_pkg::REF_Z_RST;
        phase_now        = fds_pkg::PH_ARMED;
        active_now       = 1'b0;
        tick_now         = '0;
        last_sensor_tick = '0;
        red_now          = 1'b0;
        green_now        = 1'b0;
        disp_now         = fds_pkg::DISP_BLANK;
        gen_active       = 1'b0;
        live_words       = 0;
        send_gap         = 0;
        sink_gap         = 0;
        gap_odds         = 4;
        stall_odds       = 4;
        quiet_cycles     = 0;
        words_accepted   = 0;
        results_checked  = 0;
        reg_writes       = 0;
        mismatch_count   = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        queue_directed();
        wait_drained();

        for (int p = 0; p < PASS_COUNT; p++)
        begin
            // block is idle here: nothing queued, nothing owed
            case (p)
                1:
                begin
                    gap_odds   = 0;
                    stall_odds = 0;
                    program_detector(16'd1, 8'd0, 8'sd0, 8'sd0, 8'sd0);
                end
                2:
                begin
                    gap_odds   = 3;
                    stall_odds = 5;
                    program_detector(16'd0, 8'd255, -8'sd128, 8'sd127, -8'sd128);
                end
                3:
                begin
                    gap_odds   = 4;
                    stall_odds = 3;
                    program_detector(16'hFFFF, 8'd8, 8'sd127, -8'sd128, 8'sd127);
                end
                4:
                begin
                    gap_odds   = 5;
                    stall_odds = 5;
                    program_detector(16'($urandom_range(2, 10)), 8'($urandom_range(1, 40)),
                                     rnd8(), rnd8(), rnd8());
                end
                5:
                begin
                    // closing stretch runs flat out on both sides
                    gap_odds   = 0;
                    stall_odds = 0;
                    program_detector(16'd3, fds_pkg::TILT_RST, fds_pkg::REF_X_RST,
                                     fds_pkg::REF_Y_RST, fds_pkg::REF_Z_RST);
                end
                default: ;
            endcase

            @(negedge clk);
            target = live_words + WORDS_PER_PASS;
            while (live_words < target)
                queue_episode();
            wait_drained();
        end

        // let any stray result surface before the verdict
        repeat (4) @(posedge clk);

        $display("%0d event words and %0d results over %0d register writes, six settings",
                 words_accepted, results_checked, reg_writes);
        $display("covered standby, arming, free fall, impact, fall, timeout and spare codes");
        if (mismatch_count == 0 && predicted_outcomes.size() == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, predicted_outcomes.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
sv/fds_pkg.sv
sv/fds_ifs.sv
sv/fds_cfg_regs.sv
sv/fds_step.sv
sv/fall_detect_sequencer.sv
bench/fall_detect_sequencer_tb.sv
